>>> hw/rtl/min_heap_decrease_key_defines.svh
// Assertion macros shared by the checker.
`ifndef MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`define MIN_HEAP_DECREASE_KEY_DEFINES_SVH

// Assert an implication on every rising clock edge, off during reset.
`define MHDK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication whose consequence is checked on the next clock cycle.
`define MHDK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mhdk_pkg.sv
`timescale 1ns / 1ps
package mhdk_pkg;

  localparam int unsigned HeapDepthDefault   = 1024;
  localparam int unsigned HandleSpaceDefault = 1024;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned HandleW = 10;
  localparam int unsigned DeltaW  = 31;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OccW    = 11;

  // Operation codes
  localparam logic [1:0] FuncInsert   = 2'd0;
  localparam logic [1:0] FuncGetMin   = 2'd1;
  localparam logic [1:0] FuncExtract  = 2'd2;
  localparam logic [1:0] FuncDecrease = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StEmpty   = 3'd1;
  localparam logic [StatusW-1:0] StFull    = 3'd2;
  localparam logic [StatusW-1:0] StUnknown = 3'd3;
  localparam logic [StatusW-1:0] StInUse   = 3'd4;

  localparam logic signed [KeyW-1:0] KeyMin = {1'b1, {(KeyW-1){1'b0}}};

  // Datapath operation selected by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpCheck,     // read map for request handle
    OpInsWrite,  // write new entry at end
    OpDecRead,   // read slot of decreased key
    OpDecWrite,  // write decreased key
    OpExtRead,   // read root and last entry
    OpExtMove,   // move last to root
    OpUpRead,    // read parent of cur
    OpDownRead,  // read two children of cur
    OpSwap,      // write target entry into cur slot
    OpSwapMap,   // write cur entry into target slot
    OpRootRead,  // read root for result
    OpLoad       // latch request fields and present bit
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic       present;     // handle present bit
    logic       handle_ok;   // handle within space
    logic       empty;       // no entries
    logic       full;        // heap full
    logic       up_more;     // sift up: swap needed
    logic       down_more;   // sift down: swap needed
    logic       clearing;    // present bit sweep after reset
  } dp_sts_t;

endpackage

>>> hw/rtl/mhdk_if.sv
`timescale 1ns / 1ps
interface mhdk_req_if;
  import mhdk_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic signed [KeyW-1:0]    key_value;
  logic [HandleW-1:0]        handle;
  logic [DeltaW-1:0]         delta;
  modport source (output valid, func, key_value, handle, delta, input ready);
  modport sink   (input valid, func, key_value, handle, delta, output ready);
endinterface

interface mhdk_rsp_if;
  import mhdk_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [KeyW-1:0]    min_key;
  logic [StatusW-1:0]        status;
  logic [OccW-1:0]           occupancy;
  modport source (output valid, min_key, status, occupancy, input ready);
  modport sink   (input valid, min_key, status, occupancy, output ready);
endinterface

>>> hw/rtl/min_heap_decrease_key.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_if    in         func, key_value, handle, delta
// rsp_if    out        min_key, status, occupancy
//
// One request at a time: insert checks, writes, then sifts up; decrease
// checks, reads and writes the key, then sifts up; extract checks, reads
// root and last, moves last to root, then sifts down; get-min and rejected
// requests only check. All end with a root read. Each heap memory sees one
// access per cycle. After reset a sweep clears the present bits first.
// A stalled result blocks the next request.
module min_heap_decrease_key #(
  parameter int unsigned HEAP_DEPTH   = mhdk_pkg::HeapDepthDefault,
  parameter int unsigned HANDLE_SPACE = mhdk_pkg::HandleSpaceDefault
) (
  input logic   clk_i,
  input logic   rst_ni,
  mhdk_req_if.sink   req_if,
  mhdk_rsp_if.source rsp_if
);
  import mhdk_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mhdk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_if.ready),
    .req_func_i  (req_if.func),
    .rsp_valid_o (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .status_o    (rsp_if.status),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mhdk_datapath #(
    .HeapDepth   (HEAP_DEPTH),
    .HandleSpace (HANDLE_SPACE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .key_value_i (req_if.key_value),
    .handle_i    (req_if.handle),
    .delta_i     (req_if.delta),
    .min_key_o   (rsp_if.min_key),
    .occupancy_o (rsp_if.occupancy)
  );

endmodule

>>> hw/rtl/mhdk_datapath.sv
`timescale 1ns / 1ps
module mhdk_datapath #(
  parameter int unsigned HeapDepth   = mhdk_pkg::HeapDepthDefault,
  parameter int unsigned HandleSpace = mhdk_pkg::HandleSpaceDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mhdk_pkg::dp_cmd_t                 cmd_i,
  output mhdk_pkg::dp_sts_t                 sts_o,
  input  logic signed [mhdk_pkg::KeyW-1:0]  key_value_i,
  input  logic [mhdk_pkg::HandleW-1:0]      handle_i,
  input  logic [mhdk_pkg::DeltaW-1:0]       delta_i,
  output logic signed [mhdk_pkg::KeyW-1:0]  min_key_o,
  output logic [mhdk_pkg::OccW-1:0]         occupancy_o
);
  import mhdk_pkg::*;

  localparam int unsigned SlotW = (HeapDepth > 1) ? $clog2(HeapDepth) : 1;
  localparam int unsigned HsW   = (HandleSpace > 1) ? $clog2(HandleSpace) : 1;
  localparam int unsigned CntW  = $clog2(HeapDepth + 1);
  localparam int unsigned IdxW  = SlotW + 2;

  // Heap entry memories, handle map and present bits
  logic signed [KeyW-1:0]    key_mem [HeapDepth];
  logic [HandleW-1:0]        hdl_mem [HeapDepth];
  logic [SlotW-1:0]          map_mem [HandleSpace];
  logic                      present_mem [HandleSpace];

  logic [CntW-1:0]           count_q;
  logic [SlotW-1:0]          cur_q, tgt_q;
  logic signed [KeyW-1:0]    cur_key_q;
  logic [HandleW-1:0]        cur_hdl_q;
  logic signed [KeyW-1:0]    tgt_key_q;
  logic [HandleW-1:0]        tgt_hdl_q;
  logic signed [KeyW-1:0]    rkey_q;
  logic [HandleW-1:0]        rhdl_q;
  logic signed [KeyW-1:0]    key_q;
  logic [HandleW-1:0]        hdl_q;
  logic [DeltaW-1:0]         delta_q;
  logic                      hok_q;
  logic                      pres_q;
  logic                      up_more_q, down_more_q;
  logic signed [KeyW-1:0]    root_q;
  logic [HsW-1:0]            clr_q;
  logic                      clearing_q;
  // Read phase for extract, sift up and sift down; down: 0 left, 1 right, 2 pick
  logic [1:0]                rd_phase_q;
  logic                      swap_ph_q;

  logic [HsW-1:0]            hidx;
  logic [IdxW-1:0]           lchild, rchild;
  logic signed [KeyW:0]      dec_wide;
  logic [HsW-1:0]            cur_hidx, tgt_hidx;
  logic                      dn_pick;
  logic signed [KeyW-1:0]    dn_key;
  logic [HandleW-1:0]        dn_hdl;

  assign hidx     = HsW'(hdl_q);
  assign cur_hidx = HsW'(cur_hdl_q);
  assign tgt_hidx = HsW'(tgt_hdl_q);
  assign lchild   = {1'b0, cur_q, 1'b1};
  assign rchild   = {1'b0, cur_q, 1'b0} + IdxW'(2);
  assign dec_wide = {cur_key_q[KeyW-1], cur_key_q} - {2'b00, delta_q};

  // Pick the right child only when it exists and its key is strictly lower
  assign dn_pick = (rchild < IdxW'(count_q)) && (rkey_q < tgt_key_q);
  assign dn_key  = dn_pick ? rkey_q : tgt_key_q;
  assign dn_hdl  = dn_pick ? rhdl_q : tgt_hdl_q;

  // Status back to the controller
  always_comb begin
    sts_o.present   = pres_q;
    sts_o.handle_ok = hok_q;
    sts_o.empty     = (count_q == '0);
    sts_o.full      = (count_q >= CntW'(HeapDepth));
    sts_o.up_more   = up_more_q;
    sts_o.down_more = down_more_q;
    sts_o.clearing  = clearing_q;
  end

  assign min_key_o   = (count_q == '0) ? '0 : root_q;
  assign occupancy_o = OccW'(count_q);

  // Control registers: count, sweep, read phases, swap flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      clr_q       <= '0;
      clearing_q  <= 1'b1;
      rd_phase_q  <= '0;
      swap_ph_q   <= 1'b0;
      up_more_q   <= 1'b0;
      down_more_q <= 1'b0;
    end else begin
      // Advance the present bit sweep
      if (clearing_q) begin
        clr_q <= clr_q + HsW'(1);
        if (clr_q == HsW'(HandleSpace - 1)) clearing_q <= 1'b0;
      end
      case (cmd_i.op)
        OpInsWrite: begin
          count_q   <= count_q + CntW'(1);
          up_more_q <= 1'b0;
        end
        OpExtRead: begin
          // phase 0 decrements count
          if (rd_phase_q == 2'd0) begin
            count_q <= count_q - CntW'(1);
          end
          rd_phase_q <= rd_phase_q + 2'd1;
        end
        OpExtMove: begin
          rd_phase_q  <= '0;
          down_more_q <= 1'b0;
        end
        OpDecWrite: up_more_q <= 1'b0;
        OpUpRead: begin
          // cur entry and parent latched; decide
          up_more_q <= (cur_q != '0) && (cur_key_q < tgt_key_q) && (rd_phase_q == 2'd1);
          rd_phase_q <= (rd_phase_q == 2'd1) ? 2'd0 : 2'd1;
        end
        OpDownRead: begin
          rd_phase_q <= (rd_phase_q == 2'd2) ? 2'd0 : rd_phase_q + 2'd1;
          if (rd_phase_q == 2'd2) begin
            down_more_q <= (lchild < IdxW'(count_q)) &&
                           ((cur_key_q > dn_key) ||
                            ((cur_key_q == dn_key) && (cur_hdl_q > dn_hdl)));
          end
        end
        OpSwap:    swap_ph_q <= 1'b1;
        OpSwapMap: begin
          swap_ph_q   <= 1'b0;
          up_more_q   <= 1'b0;
          down_more_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers and memory access
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OpNone: begin
        // clear one present bit per cycle after reset
        if (clearing_q) present_mem[clr_q] <= 1'b0;
      end
      OpLoad: begin
        key_q   <= key_value_i;
        hdl_q   <= handle_i;
        delta_q <= delta_i;
        hok_q   <= (32'(handle_i) < HandleSpace);
        pres_q  <= present_mem[HsW'(handle_i)];
      end
      OpCheck: cur_q <= map_mem[hidx];
      OpInsWrite: begin
        key_mem[count_q[SlotW-1:0]] <= key_q;
        hdl_mem[count_q[SlotW-1:0]] <= hdl_q;
        map_mem[hidx]               <= count_q[SlotW-1:0];
        present_mem[hidx]           <= 1'b1;
        cur_q                       <= count_q[SlotW-1:0];
        cur_key_q                   <= key_q;
        cur_hdl_q                   <= hdl_q;
      end
      OpDecRead: begin
        cur_key_q <= key_mem[cur_q];
        cur_hdl_q <= hdl_q;
      end
      OpDecWrite: begin
        cur_key_q <= (dec_wide < $signed({KeyMin[KeyW-1], KeyMin})) ? KeyMin
                                                                     : dec_wide[KeyW-1:0];
        key_mem[cur_q] <= (dec_wide < $signed({KeyMin[KeyW-1], KeyMin})) ? KeyMin
                                                                          : dec_wide[KeyW-1:0];
      end
      OpExtRead: begin
        // phase 0: root, phase 1: last (count already reduced)
        if (rd_phase_q == 2'd0) begin
          cur_hdl_q <= hdl_mem[0];
          cur_q     <= '0;
        end else begin
          tgt_key_q <= key_mem[count_q[SlotW-1:0]];
          tgt_hdl_q <= hdl_mem[count_q[SlotW-1:0]];
          // root handle fetched; drop its present bit
          present_mem[cur_hidx] <= 1'b0;
        end
      end
      OpExtMove: begin
        if (count_q != '0) begin
          key_mem[0]         <= tgt_key_q;
          hdl_mem[0]         <= tgt_hdl_q;
          map_mem[tgt_hidx]  <= '0;
        end
        cur_key_q <= tgt_key_q;
        cur_hdl_q <= tgt_hdl_q;
        cur_q     <= '0;
      end
      OpUpRead: begin
        tgt_q     <= SlotW'((cur_q - SlotW'(1)) >> 1);
        tgt_key_q <= key_mem[SlotW'((cur_q - SlotW'(1)) >> 1)];
        tgt_hdl_q <= hdl_mem[SlotW'((cur_q - SlotW'(1)) >> 1)];
      end
      OpDownRead: begin
        case (rd_phase_q)
          2'd0: begin
            tgt_q     <= lchild[SlotW-1:0];
            tgt_key_q <= key_mem[lchild[SlotW-1:0]];
            tgt_hdl_q <= hdl_mem[lchild[SlotW-1:0]];
          end
          2'd1: begin
            rkey_q <= key_mem[rchild[SlotW-1:0]];
            rhdl_q <= hdl_mem[rchild[SlotW-1:0]];
          end
          2'd2: begin
            if (dn_pick) begin
              tgt_q     <= rchild[SlotW-1:0];
              tgt_key_q <= rkey_q;
              tgt_hdl_q <= rhdl_q;
            end
          end
          default: ;
        endcase
      end
      OpSwap: begin
        key_mem[cur_q]    <= tgt_key_q;
        hdl_mem[cur_q]    <= tgt_hdl_q;
        map_mem[cur_hidx] <= tgt_q;
      end
      OpSwapMap: begin
        key_mem[tgt_q]    <= cur_key_q;
        hdl_mem[tgt_q]    <= cur_hdl_q;
        map_mem[tgt_hidx] <= cur_q;
        cur_q             <= tgt_q;
      end
      OpRootRead: root_q <= key_mem[0];
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/mhdk_ctrl.sv
`timescale 1ns / 1ps
module mhdk_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [1:0]                   req_func_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic [mhdk_pkg::StatusW-1:0] status_o,
  output mhdk_pkg::dp_cmd_t            cmd_o,
  input  mhdk_pkg::dp_sts_t            sts_i
);
  import mhdk_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SCheck, SIns, SDecRd, SDecWr, SExtRd0, SExtRd1, SExtMv,
    SUpRd0, SUpRd1, SDnRd0, SDnRd1, SDnRd2, SSwap, SSwapMap, SRoot
  } state_e;

  state_e              state_q;
  logic [1:0]          func_q;
  logic                down_q;
  logic [StatusW-1:0]  status_q;
  logic                rsp_valid_q;
  logic                swap_go;

  assign req_ready_o = (state_q == SIdle) && !rsp_valid_q && !sts_i.clearing;
  assign rsp_valid_o = rsp_valid_q;
  assign status_o    = status_q;

  // Swap decision registered in the read phase
  assign swap_go = (down_q && sts_i.down_more) || (!down_q && sts_i.up_more);

  // Command for the current state
  always_comb begin
    cmd_o.op = OpNone;
    case (state_q)
      SIdle:    cmd_o.op = (req_valid_i && req_ready_o) ? OpLoad : OpNone;
      SCheck:   cmd_o.op = OpCheck;
      SIns:     cmd_o.op = OpInsWrite;
      SDecRd:   cmd_o.op = OpDecRead;
      SDecWr:   cmd_o.op = OpDecWrite;
      SExtRd0:  cmd_o.op = OpExtRead;
      SExtRd1:  cmd_o.op = OpExtRead;
      SExtMv:   cmd_o.op = OpExtMove;
      SUpRd0:   cmd_o.op = OpUpRead;
      SUpRd1:   cmd_o.op = OpUpRead;
      SDnRd0:   cmd_o.op = OpDownRead;
      SDnRd1:   cmd_o.op = OpDownRead;
      SDnRd2:   cmd_o.op = OpDownRead;
      SSwap:    cmd_o.op = swap_go ? OpSwap : OpNone;
      SSwapMap: cmd_o.op = OpSwapMap;
      SRoot:    cmd_o.op = OpRootRead;
      default:  cmd_o.op = OpNone;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      func_q      <= FuncGetMin;
      down_q      <= 1'b0;
      status_q    <= StOk;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (req_valid_i && req_ready_o) begin
            func_q   <= req_func_i;
            status_q <= StOk;
            state_q  <= SCheck;
          end
        end
        SCheck: begin
          state_q <= SRoot;
          case (func_q)
            FuncInsert: begin
              if (!sts_i.handle_ok)   status_q <= StUnknown;
              else if (sts_i.present) status_q <= StInUse;
              else if (sts_i.full)    status_q <= StFull;
              else                    state_q  <= SIns;
            end
            FuncGetMin:  if (sts_i.empty) status_q <= StEmpty;
            FuncExtract: begin
              if (sts_i.empty) status_q <= StEmpty;
              else             state_q  <= SExtRd0;
            end
            default: begin
              if (!sts_i.handle_ok || !sts_i.present) status_q <= StUnknown;
              else                                     state_q  <= SDecRd;
            end
          endcase
        end
        SIns:    begin down_q <= 1'b0; state_q <= SUpRd0; end
        SDecRd:  state_q <= SDecWr;
        SDecWr:  begin down_q <= 1'b0; state_q <= SUpRd0; end
        SExtRd0: state_q <= SExtRd1;
        SExtRd1: state_q <= SExtMv;
        SExtMv:  begin down_q <= 1'b1; state_q <= SDnRd0; end
        SUpRd0:  state_q <= SUpRd1;
        SUpRd1:  state_q <= SSwap;
        SDnRd0:  state_q <= SDnRd1;
        SDnRd1:  state_q <= SDnRd2;
        SDnRd2:  state_q <= SSwap;
        SSwap: begin
          if (swap_go) state_q <= SSwapMap;
          else         state_q <= SRoot;
        end
        SSwapMap: state_q <= down_q ? SDnRd0 : SUpRd0;
        SRoot: begin
          rsp_valid_q <= 1'b1;
          state_q     <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

>>> hw/rtl/mhdk_checker.sv
`timescale 1ns / 1ps
`include "min_heap_decrease_key_defines.svh"
module mhdk_assert (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_vld_i,
  input logic                         req_rdy_i,
  input logic                         rsp_vld_i,
  input logic                         rsp_rdy_i,
  input logic [mhdk_pkg::StatusW-1:0] status_i,
  input logic [mhdk_pkg::OccW-1:0]    occ_i,
  input logic signed [mhdk_pkg::KeyW-1:0] key_i
);
  import mhdk_pkg::*;

  // Hold a result until taken
  `MHDK_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_vld_i && !rsp_rdy_i, rsp_vld_i, "result lost")
  // Never take a request while a result waits
  `MHDK_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, rsp_vld_i, !req_rdy_i, "request during result")
  // Empty heap reports zero key
  `MHDK_ASSERT_IMP(a_empty, clk_i, rst_ni, rsp_vld_i && occ_i == '0, key_i == '0, "nonzero key")
  // Status codes stay in range
  `MHDK_ASSERT_IMP(a_status, clk_i, rst_ni, rsp_vld_i, status_i <= StInUse, "bad status")
endmodule

bind min_heap_decrease_key mhdk_assert u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_vld_i (req_if.valid),
  .req_rdy_i (req_if.ready),
  .rsp_vld_i (rsp_if.valid),
  .rsp_rdy_i (rsp_if.ready),
  .status_i  (rsp_if.status),
  .occ_i     (rsp_if.occupancy),
  .key_i     (rsp_if.min_key)
);

>>> tb/sv/mhdk_checker.sv
`timescale 1ns / 1ps
module mhdk_checker
  import mhdk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mhdk_req_if  req_if,
  mhdk_rsp_if  rsp_if,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned Depth   = HeapDepthDefault;
  localparam int unsigned Handles = HandleSpaceDefault;
  localparam longint      LowestKey = -64'sd2147483648;

  typedef struct packed {
    logic signed [KeyW-1:0] min_key;
    logic [StatusW-1:0]     status;
    logic [OccW-1:0]        occupancy;
  } heap_result_t;

  // Own copy of the heap, kept in step with accepted requests
  longint            slot_key  [Depth];
  logic [HandleW-1:0] slot_hnd [Depth];
  int unsigned       hnd_slot  [Handles];
  bit                hnd_live  [Handles];
  int unsigned       entries;

  heap_result_t heap_results_q[$];

  function automatic void swap_entries(int unsigned a, int unsigned b);
    longint             k;
    logic [HandleW-1:0] h;
    k = slot_key[a];
    h = slot_hnd[a];
    slot_key[a] = slot_key[b];
    slot_hnd[a] = slot_hnd[b];
    slot_key[b] = k;
    slot_hnd[b] = h;
    hnd_slot[slot_hnd[a]] = a;
    hnd_slot[slot_hnd[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned pos);
    int unsigned par;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!(slot_key[pos] < slot_key[par])) break;
      swap_entries(pos, par);
      pos = par;
    end
  endfunction

  function automatic void bubble_down(int unsigned pos);
    int unsigned c;
    bit          larger;
    while (2 * pos + 1 < entries) begin
      c = 2 * pos + 1;
      if (c + 1 < entries && slot_key[c+1] < slot_key[c]) c++;
      // parent wins on key, then on handle
      if (slot_key[pos] != slot_key[c]) larger = slot_key[pos] > slot_key[c];
      else larger = slot_hnd[pos] > slot_hnd[c];
      if (!larger) break;
      swap_entries(pos, c);
      pos = c;
    end
  endfunction

  function automatic heap_result_t apply_request(logic [1:0] func,
                                                 logic signed [KeyW-1:0] key,
                                                 logic [HandleW-1:0] h,
                                                 logic [DeltaW-1:0] delta);
    heap_result_t r;
    int unsigned  last;
    longint       nk;
    r.status = StOk;
    case (func)
      FuncInsert: begin
        if (h >= Handles) r.status = StUnknown;
        else if (hnd_live[h]) r.status = StInUse;
        else if (entries >= Depth) r.status = StFull;
        else begin
          slot_key[entries] = longint'(key);
          slot_hnd[entries] = h;
          hnd_slot[h] = entries;
          hnd_live[h] = 1'b1;
          entries++;
          bubble_up(entries - 1);
        end
      end
      FuncGetMin: begin
        if (entries == 0) r.status = StEmpty;
      end
      FuncExtract: begin
        if (entries == 0) r.status = StEmpty;
        else begin
          last = entries - 1;
          hnd_live[slot_hnd[0]] = 1'b0;
          if (last != 0) begin
            slot_key[0] = slot_key[last];
            slot_hnd[0] = slot_hnd[last];
            hnd_slot[slot_hnd[0]] = 0;
          end
          entries = last;
          bubble_down(0);
        end
      end
      default: begin
        if (h >= Handles || !hnd_live[h]) r.status = StUnknown;
        else begin
          nk = slot_key[hnd_slot[h]] - longint'(delta);
          if (nk < LowestKey) nk = LowestKey;
          slot_key[hnd_slot[h]] = nk;
          bubble_up(hnd_slot[h]);
        end
      end
    endcase
    r.min_key   = (entries > 0) ? slot_key[0][KeyW-1:0] : '0;
    r.occupancy = entries[OccW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // Compare results first, then fold in the request taken on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    heap_result_t next_r;
    if (!rst_ni) begin
      for (int i = 0; i < Handles; i++) hnd_live[i] = 1'b0;
      entries = 0;
      heap_results_q.delete();
      fail_count_o = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (heap_results_q.size() == 0) begin
          report_mismatch("unexpected result, status", rsp_if.status, -1);
        end else begin
          want = heap_results_q.pop_front();
          if (rsp_if.min_key !== want.min_key)
            report_mismatch("min_key", rsp_if.min_key, want.min_key);
          if (rsp_if.status !== want.status)
            report_mismatch("status", rsp_if.status, want.status);
          if (rsp_if.occupancy !== want.occupancy)
            report_mismatch("occupancy", rsp_if.occupancy, want.occupancy);
        end
      end
      if (req_if.valid && req_if.ready) begin
        next_r = apply_request(req_if.func, req_if.key_value,
                               req_if.handle, req_if.delta);
        heap_results_q.insert(heap_results_q.size(), next_r);
      end
    end
    pending_o = heap_results_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mhdk_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int HoldOffAt  = 400;
  localparam int HoldOffLen = 700;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   rsp_taken = 0;
  bit   steady = 1'b0;

  mhdk_req_if req_if ();
  mhdk_rsp_if rsp_if ();

  min_heap_decrease_key uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .rsp_if (rsp_if)
  );

  mhdk_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_if       (req_if),
    .rsp_if       (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    req_if.valid     = 1'b0;
    req_if.func      = FuncGetMin;
    req_if.key_value = '0;
    req_if.handle    = '0;
    req_if.delta     = '0;
    rsp_if.ready     = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one request, after a random idle gap (possibly none) unless in a steady stretch
  task automatic send_request(logic [1:0] func, logic signed [KeyW-1:0] key,
                             logic [HandleW-1:0] h, logic [DeltaW-1:0] delta);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= func;
    req_if.key_value <= key;
    req_if.handle    <= h;
    req_if.delta     <= delta;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [KeyW-1:0] pick_key();
    if ($urandom_range(0, 1)) return $urandom;
    return $signed($urandom_range(0, 200)) - 100;
  endfunction

  function automatic logic [DeltaW-1:0] pick_delta();
    case ($urandom_range(0, 4))
      0:       return '0;
      1, 2:    return DeltaW'($urandom_range(0, 50));
      default: return DeltaW'($urandom);
    endcase
  endfunction

  // Mixed operations; a narrow handle pool makes hits and clashes common
  task automatic send_mixed(int n, int extract_pct, bit wide_handles);
    int                 r;
    logic [1:0]         func;
    logic [HandleW-1:0] h;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < extract_pct) func = FuncExtract;
      else if (r < extract_pct + 10) func = FuncGetMin;
      else if (r < extract_pct + 45) func = FuncDecrease;
      else func = FuncInsert;
      h = (wide_handles || $urandom_range(0, 4) == 0) ? HandleW'($urandom)
                                                      : HandleW'($urandom_range(0, 47));
      send_request(func, pick_key(), h, pick_delta());
    end
  endtask

  // Receiver: random stalls, one long hold-off to back the block up
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = (rsp_taken == HoldOffAt) ? HoldOffLen
             : (steady ? 0 : $urandom_range(0, 11));
      if (wait_n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      rsp_taken++;
    end
  end

  initial begin
    int drain;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, key extremes, clashes, ties, saturation
    send_request(FuncGetMin,   '0, '0, '0);
    send_request(FuncExtract,  '0, '0, '0);
    send_request(FuncDecrease, '0, 10'd5, 31'd1);
    send_request(FuncInsert,   32'sh7fffffff, 10'd1023, '0);
    send_request(FuncInsert,   KeyMin, 10'd0, '0);
    send_request(FuncInsert,   32'sd9, 10'd1023, '0);
    send_request(FuncInsert,   32'sd0, 10'd512, '0);
    send_request(FuncInsert,   32'sd0, 10'd3, '0);
    send_request(FuncInsert,   32'sd0, 10'd341, '0);
    send_request(FuncDecrease, '0, 10'd1023, 31'h7fffffff);
    send_request(FuncDecrease, '0, 10'd0, 31'h7fffffff);
    send_request(FuncDecrease, '0, 10'd512, 31'd0);
    send_request(FuncGetMin,   '0, '0, '0);
    repeat (6) send_request(FuncExtract, '0, '0, '0);
    send_request(FuncInsert,   -32'sd5, 10'd7, '0);
    send_request(FuncDecrease, '0, 10'd7, 31'd1);
    send_request(FuncExtract,  '0, '0, '0);
    send_request(FuncGetMin,   '0, '0, '0);

    // Random phases: churn, fill with every handle, then mixed on a full heap
    send_mixed(400, 25, 1'b0);
    steady = 1'b0;
    for (int h = 0; h < HandleSpaceDefault; h++) begin
      if (h % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      send_request(FuncInsert, pick_key(), h[HandleW-1:0], '0);
    end
    send_mixed(300, 40, 1'b1);
    steady = 1'b0;
    req_if.valid <= 1'b0;

    // Drain outstanding results
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mhdk_pkg.sv
hw/rtl/mhdk_if.sv
hw/rtl/mhdk_datapath.sv
hw/rtl/mhdk_ctrl.sv
hw/rtl/min_heap_decrease_key.sv
hw/rtl/mhdk_checker.sv
tb/sv/mhdk_checker.sv
tb/sv/tb_top.sv
